@@ design/blp_pkg.sv @@
// ----------------------------------------------------------------------------
// blp_pkg: shared constants and types for the breathing led pwm unit
// Register indexes, reset values and the divide-by-100 reciprocal.
// ----------------------------------------------------------------------------
package blp_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned DUTY_W   = 7;
  localparam int unsigned CFG_IDX_W = 2;
  // period * duty, 16 x 7 bits
  localparam int unsigned PROD_W   = PERIOD_W + DUTY_W;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  typedef logic [PERIOD_W-1:0]  count_t;
  typedef logic [DUTY_W-1:0]    duty_t;

  localparam cfg_idx_t CFG_PERIOD = 2'd0;
  localparam cfg_idx_t CFG_STEP   = 2'd1;
  localparam cfg_idx_t CFG_RUN    = 2'd2;

  localparam count_t PERIOD_RST = 16'd1000;
  localparam duty_t  STEP_RST   = 7'd2;
  localparam duty_t  DUTY_FULL  = 7'd100;
  localparam duty_t  DUTY_ZERO  = 7'd0;

  // floor(x/100) = (x * ceil(2^30/100)) >> 30, exact for any x below 2^23
  localparam int unsigned       DIV100_SHIFT = 30;
  localparam int unsigned       MAGIC_W      = 24;
  localparam logic [MAGIC_W-1:0] DIV100_MAGIC = 24'd10737419;

endpackage

@@ design/breathing_led_pwm_unit.sv @@
// ----------------------------------------------------------------------------
// breathing_led_pwm_unit: triangle-ramped pwm led dimmer
// A 16-bit up-counting timer with on/off reloads drives the pin; each ramp
// tick moves the duty percent and, between 0 and 100, recomputes the reloads from the period.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------
//  in      | input     | in_valid/in_stall   | in_timer_tick, in_ramp_tick
//  out     | output    | out_valid/out_stall | out_pwm_out, out_duty_now, out_ramp_up
//  cfg     | input     | cfg_we              | cfg_index, cfg_wdata
//
//  a transaction without a ramp tick shows its result in the output register on the
//  next cycle and a new transaction can follow at once
//  a ramp tick that lands on a duty strictly between 0 and 100 also updates the reloads:
//  the period*duty product is registered, then divided by 100 through a
//  reciprocal multiply into the reload registers, and in_stall is high meanwhile
//  in_stall also follows out_stall while the output register holds a result
//  synchronous active-low reset runs the start-up sequence with period 1000
// ----------------------------------------------------------------------------
module breathing_led_pwm_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_timer_tick,
  input  logic                           in_ramp_tick,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_pwm_out,
  output logic [blp_pkg::DUTY_W-1:0]     out_duty_now,
  output logic                           out_ramp_up,
  // configuration
  input  logic                           cfg_we,
  input  logic [blp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blp_pkg::PERIOD_W-1:0]   cfg_wdata
);

  localparam int unsigned QUO_W = blp_pkg::PROD_W + blp_pkg::MAGIC_W;

  // configuration
  blp_pkg::count_t period_r, period_nxt;
  blp_pkg::duty_t  step_r, step_nxt;
  logic            run_r, run_nxt;

  // timer and pin state
  blp_pkg::count_t timer_r, timer_nxt;
  blp_pkg::count_t on_rel_r, on_rel_nxt;
  blp_pkg::count_t off_rel_r, off_rel_nxt;
  logic            pin_r, pin_nxt;
  logic            tog_r, tog_nxt;
  blp_pkg::duty_t  duty_r, duty_nxt;
  logic            rising_r, rising_nxt;

  // reload computation stage
  logic                          s1_v_r, s1_v_nxt;
  logic                          pend_load_r, pend_load_nxt;
  logic [blp_pkg::PROD_W-1:0]    prod_r, prod_nxt;

  // result register
  logic            out_valid_r, out_valid_nxt;
  logic            out_pwm_r, out_pwm_nxt;
  blp_pkg::duty_t  out_duty_r, out_duty_nxt;
  logic            out_up_r, out_up_nxt;

  logic                        accept;
  logic [blp_pkg::DUTY_W:0]    duty_sum;
  logic [QUO_W-1:0]            quo_full;
  blp_pkg::count_t             on_time;
  blp_pkg::count_t             off_time;
  blp_pkg::count_t             timer_inc;
  blp_pkg::count_t             half;
  blp_pkg::count_t             su_on;
  logic                        start_calc;

  assign in_stall = s1_v_r || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  assign duty_sum  = {1'b0, duty_r} + {1'b0, step_r};
  assign quo_full  = QUO_W'(prod_r) * QUO_W'(blp_pkg::DIV100_MAGIC);
  assign on_time   = quo_full[blp_pkg::DIV100_SHIFT +: blp_pkg::PERIOD_W];
  assign off_time  = period_r - on_time;
  assign timer_inc = timer_r + 16'd1;
  assign half      = {1'b0, cfg_wdata[blp_pkg::PERIOD_W-1:1]};
  assign su_on     = 16'd0 - half;

  always_comb begin
    period_nxt    = period_r;
    step_nxt      = step_r;
    run_nxt       = run_r;
    timer_nxt     = timer_r;
    on_rel_nxt    = on_rel_r;
    off_rel_nxt   = off_rel_r;
    pin_nxt       = pin_r;
    tog_nxt       = tog_r;
    duty_nxt      = duty_r;
    rising_nxt    = rising_r;
    s1_v_nxt      = 1'b0;
    pend_load_nxt = 1'b0;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pwm_nxt   = out_pwm_r;
    out_duty_nxt  = out_duty_r;
    out_up_nxt    = out_up_r;
    start_calc    = 1'b0;

    // once the product is registered: reloads land, and a deferred timer load takes them
    if (s1_v_r) begin
      on_rel_nxt  = 16'd0 - on_time;
      off_rel_nxt = 16'd0 - off_time;
      if (pend_load_r) begin
        timer_nxt = pin_r ? on_rel_nxt : off_rel_nxt;
      end
    end

    if (accept) begin
      if (in_ramp_tick) begin
        if (rising_r) begin
          duty_nxt = (duty_sum >= {1'b0, blp_pkg::DUTY_FULL}) ? blp_pkg::DUTY_FULL
                                                               : duty_sum[blp_pkg::DUTY_W-1:0];
          if (duty_nxt == blp_pkg::DUTY_FULL) begin
            rising_nxt = 1'b0;
          end
        end else begin
          duty_nxt = (duty_r > step_r) ? duty_r - step_r : blp_pkg::DUTY_ZERO;
          if (duty_nxt == blp_pkg::DUTY_ZERO) begin
            rising_nxt = 1'b1;
          end
        end
        if (duty_nxt == blp_pkg::DUTY_ZERO) begin
          pin_nxt = 1'b0;
          tog_nxt = 1'b0;
        end else if (duty_nxt == blp_pkg::DUTY_FULL) begin
          pin_nxt = 1'b1;
          tog_nxt = 1'b0;
        end else begin
          tog_nxt    = 1'b1;
          start_calc = 1'b1;
          s1_v_nxt   = 1'b1;
          prod_nxt   = blp_pkg::PROD_W'(period_r) * blp_pkg::PROD_W'(duty_nxt);
        end
      end

      if (in_timer_tick && run_r) begin
        timer_nxt = timer_inc;
        if (timer_inc == 16'd0 && tog_nxt) begin
          pin_nxt = !pin_nxt;
          // new reloads are not ready yet, load them next cycle
          if (start_calc) begin
            pend_load_nxt = 1'b1;
          end else begin
            timer_nxt = pin_nxt ? on_rel_r : off_rel_r;
          end
        end
      end

      out_valid_nxt = 1'b1;
      out_pwm_nxt   = pin_nxt;
      out_duty_nxt  = duty_nxt;
      out_up_nxt    = rising_nxt;
    end

    if (cfg_we) begin
      unique case (cfg_index)
        blp_pkg::CFG_PERIOD: begin
          period_nxt    = cfg_wdata;
          on_rel_nxt    = su_on;
          off_rel_nxt   = 16'd0 - (cfg_wdata - half);
          timer_nxt     = su_on;
          pin_nxt       = 1'b0;
          tog_nxt       = 1'b0;
          duty_nxt      = blp_pkg::DUTY_ZERO;
          rising_nxt    = 1'b1;
          s1_v_nxt      = 1'b0;
          pend_load_nxt = 1'b0;
        end
        blp_pkg::CFG_STEP: begin
          step_nxt = cfg_wdata[blp_pkg::DUTY_W-1:0];
        end
        blp_pkg::CFG_RUN: begin
          run_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= blp_pkg::PERIOD_RST;
      step_r      <= blp_pkg::STEP_RST;
      run_r       <= 1'b1;
      timer_r     <= 16'd0 - (blp_pkg::PERIOD_RST >> 1);
      on_rel_r    <= 16'd0 - (blp_pkg::PERIOD_RST >> 1);
      off_rel_r   <= 16'd0 - (blp_pkg::PERIOD_RST - (blp_pkg::PERIOD_RST >> 1));
      pin_r       <= 1'b0;
      tog_r       <= 1'b0;
      duty_r      <= blp_pkg::DUTY_ZERO;
      rising_r    <= 1'b1;
      s1_v_r      <= 1'b0;
      pend_load_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      period_r    <= period_nxt;
      step_r      <= step_nxt;
      run_r       <= run_nxt;
      timer_r     <= timer_nxt;
      on_rel_r    <= on_rel_nxt;
      off_rel_r   <= off_rel_nxt;
      pin_r       <= pin_nxt;
      tog_r       <= tog_nxt;
      duty_r      <= duty_nxt;
      rising_r    <= rising_nxt;
      s1_v_r      <= s1_v_nxt;
      pend_load_r <= pend_load_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_pwm_r  <= out_pwm_nxt;
    out_duty_r <= out_duty_nxt;
    out_up_r   <= out_up_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_pwm_out  = out_pwm_r;
  assign out_duty_now = out_duty_r;
  assign out_ramp_up  = out_up_r;

endmodule

@@ design/blp_checker.sv @@
// ----------------------------------------------------------------------------
// blp_checker: port-level checks for breathing_led_pwm_unit
// Watches the channel ports and the result payload over time.
// ----------------------------------------------------------------------------
module blp_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_pwm_out,
  input logic [blp_pkg::DUTY_W-1:0]  out_duty_now,
  input logic                        out_ramp_up
);

  // a held result keeps its payload
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pwm_out)
      && $stable(out_duty_now) && $stable(out_ramp_up))
    else $error("stalled result changed");

  // every accepted transaction shows a result on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction gave no result");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_now <= blp_pkg::DUTY_FULL)
    else $error("duty above full scale");

  // end points force the pin
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_duty_now == blp_pkg::DUTY_ZERO || out_duty_now == blp_pkg::DUTY_FULL)
      |-> out_pwm_out == (out_duty_now == blp_pkg::DUTY_FULL))
    else $error("pin not forced at duty end point");

  // ramp direction turns at the end points
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_duty_now == blp_pkg::DUTY_ZERO || out_duty_now == blp_pkg::DUTY_FULL)
      |-> out_ramp_up == (out_duty_now == blp_pkg::DUTY_ZERO))
    else $error("ramp direction wrong at end point");

endmodule

bind breathing_led_pwm_unit blp_checker u_blp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_pwm_out  (out_pwm_out),
  .out_duty_now (out_duty_now),
  .out_ramp_up  (out_ramp_up)
);

@@ tb/breathing_led_pwm_unit_tb.sv @@
// ----------------------------------------------------------------------------
// breathing_led_pwm_unit_tb: self-checking bench for the breathing led pwm unit
// Drives tick transactions and register writes with random gaps and output
// stalls. A behavioral model of the timer, reloads and duty ramp predicts
// every result, and each one is checked field by field in order.
// ----------------------------------------------------------------------------
module breathing_led_pwm_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import blp_pkg::*;

  localparam cfg_idx_t CFG_NONE = 2'd3;
  localparam int       PHASES   = 10;
  localparam int       PHASE_ITEMS = 60;

  typedef struct packed {
    logic  pwm;
    duty_t duty;
    logic  up;
  } led_state_t;

  logic     clk;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  logic     in_timer_tick = 1'b0;
  logic     in_ramp_tick = 1'b0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  logic     out_pwm_out;
  duty_t    out_duty_now;
  logic     out_ramp_up;
  logic     cfg_we = 1'b0;
  cfg_idx_t cfg_index = CFG_PERIOD;
  count_t   cfg_wdata = '0;

  // led model state
  count_t m_period;
  duty_t  m_step;
  logic   m_run;
  count_t m_timer;
  logic   m_pin;
  logic   m_toggling;
  count_t m_on_reload;
  count_t m_off_reload;
  duty_t  m_duty;
  logic   m_rising;

  led_state_t led_q[$];

  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int pin_changes = 0;
  logic last_pwm = 1'b0;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;

  breathing_led_pwm_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_timer_tick (in_timer_tick),
    .in_ramp_tick  (in_ramp_tick),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pwm_out   (out_pwm_out),
    .out_duty_now  (out_duty_now),
    .out_ramp_up   (out_ramp_up),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- led model

  function automatic count_t reload_for(count_t t);
    return count_t'(0) - t;
  endfunction

  function automatic void load_duty(duty_t d);
    logic [31:0] prod;
    count_t      on_t;
    if (d == DUTY_ZERO) begin
      m_pin = 1'b0;
      m_toggling = 1'b0;
    end else if (d == DUTY_FULL) begin
      m_pin = 1'b1;
      m_toggling = 1'b0;
    end else begin
      prod = 32'(m_period) * 32'(d);
      on_t = count_t'(prod / DUTY_FULL);
      m_on_reload = reload_for(on_t);
      m_off_reload = reload_for(m_period - on_t);
      m_toggling = 1'b1;
    end
  endfunction

  function automatic void restart_sequence();
    count_t half;
    half = m_period >> 1;
    m_on_reload = reload_for(half);
    m_off_reload = reload_for(m_period - half);
    m_timer = m_on_reload;
    m_duty = DUTY_ZERO;
    m_rising = 1'b1;
    load_duty(DUTY_ZERO);
  endfunction

  function automatic void model_reset();
    m_period = PERIOD_RST;
    m_step = STEP_RST;
    m_run = 1'b1;
    restart_sequence();
  endfunction

  function automatic void model_write(cfg_idx_t idx, count_t data);
    case (idx)
      CFG_PERIOD: begin
        m_period = data;
        restart_sequence();
      end
      CFG_STEP: m_step = duty_t'(data);
      CFG_RUN:  m_run = data[0];
      default: ;
    endcase
  endfunction

  function automatic led_state_t model_step(logic tick, logic ramp);
    logic [7:0] sum;
    if (ramp) begin
      if (m_rising) begin
        sum = {1'b0, m_duty} + {1'b0, m_step};
        m_duty = (sum >= 8'(DUTY_FULL)) ? DUTY_FULL : sum[6:0];
        if (m_duty == DUTY_FULL) m_rising = 1'b0;
      end else begin
        m_duty = (m_duty > m_step) ? m_duty - m_step : DUTY_ZERO;
        if (m_duty == DUTY_ZERO) m_rising = 1'b1;
      end
      load_duty(m_duty);
    end
    if (tick && m_run) begin
      m_timer = m_timer + 16'd1;
      if (m_timer == '0 && m_toggling) begin
        m_pin = ~m_pin;
        m_timer = m_pin ? m_on_reload : m_off_reload;
      end
    end
    return '{pwm: m_pin, duty: m_duty, up: m_rising};
  endfunction

  // ----------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin : result_check
    led_state_t want;
    if (!rst_n) begin
      model_reset();
      led_q.delete();
    end else begin
      if (cfg_we) model_write(cfg_index, cfg_wdata);
      if (in_valid && !in_stall) begin
        led_q.push_back(model_step(in_timer_tick, in_ramp_tick));
        items_sent++;
      end
      if (out_valid && !out_stall) begin
        if (led_q.size() == 0) begin
          report_mismatch("result transaction with nothing pending");
        end else begin
          want = led_q.pop_front();
          results_checked++;
          if (out_pwm_out !== want.pwm)
            report_mismatch($sformatf("pwm_out got %b expected %b", out_pwm_out, want.pwm));
          if (out_duty_now !== want.duty)
            report_mismatch($sformatf("duty_now got %0d expected %0d",
                                      out_duty_now, want.duty));
          if (out_ramp_up !== want.up)
            report_mismatch($sformatf("ramp_up got %b expected %b", out_ramp_up, want.up));
        end
        if (out_pwm_out !== last_pwm) begin
          pin_changes++;
          last_pwm = out_pwm_out;
        end
      end
    end
  end

  // ------------------------------------------------------------------ driving

  // mostly short idle stretches, now and then a long one
  function automatic int idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 25);
    return $urandom_range(1, 3);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if ($urandom_range(0, 99) < stall_pct) stall_left = idle_len();
    out_stall <= (stall_left > 0);
  end

  // valid stays high across back-to-back transactions
  task automatic send_item(input logic tick, input logic ramp);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_timer_tick <= tick;
    in_ramp_tick <= ramp;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (led_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input count_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // -------------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_item(1'b0, 1'b0);
    send_item(1'b1, 1'b0);
    send_item(1'b0, 1'b0);
    drain_and_idle();
  endtask

  // timer starts three counts below overflow and wraps with toggling off
  task automatic test_wrap_without_toggle();
    write_reg(CFG_PERIOD, 16'd6);
    repeat (4) send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b1);
    drain_and_idle();
  endtask

  // half duty on a short period flips the pin every two ticks
  task automatic test_toggle_levels();
    write_reg(CFG_PERIOD, 16'd4);
    write_reg(CFG_STEP, 16'hFF32);
    send_item(1'b1, 1'b1);
    repeat (5) send_item(1'b1, 1'b0);
    drain_and_idle();
  endtask

  task automatic test_duty_clamp();
    write_reg(CFG_STEP, 16'(DUTY_FULL));
    send_item(1'b0, 1'b1);
    send_item(1'b0, 1'b1);
    drain_and_idle();
    write_reg(CFG_STEP, 16'h007F);
    send_item(1'b1, 1'b1);
    drain_and_idle();
    // zero step leaves the duty parked at full
    write_reg(CFG_STEP, 16'h0000);
    send_item(1'b0, 1'b1);
    drain_and_idle();
  endtask

  task automatic test_halt_and_period_extremes();
    write_reg(CFG_RUN, 16'hFFFE);
    send_item(1'b1, 1'b0);
    send_item(1'b1, 1'b0);
    drain_and_idle();
    write_reg(CFG_NONE, 16'hFFFF);
    write_reg(CFG_RUN, 16'h0001);
    write_reg(CFG_STEP, 16'd3);
    write_reg(CFG_PERIOD, 16'd0);
    send_item(1'b1, 1'b1);
    drain_and_idle();
    write_reg(CFG_PERIOD, 16'hFFFF);
    send_item(1'b1, 1'b1);
    send_item(1'b1, 1'b1);
    drain_and_idle();
  endtask

  function automatic count_t pick_period();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: return 16'd0;
          1: return 16'd1;
          default: return 16'hFFFF;
        endcase
      end
      1: return count_t'($urandom);
      default: return count_t'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic duty_t pick_step();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 2))
          0: return DUTY_ZERO;
          1: return DUTY_FULL;
          default: return 7'h7F;
        endcase
      end
      1: return duty_t'($urandom_range(13, 99));
      default: return duty_t'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic test_random_phases();
    int tick_pct;
    int ramp_pct;
    for (int p = 0; p < PHASES; p++) begin
      gap_pct = (p == 0) ? 0 : $urandom_range(0, 60);
      stall_pct = (p == 0) ? 0 : $urandom_range(0, 60);
      if ($urandom_range(0, 3) != 0) write_reg(CFG_PERIOD, pick_period());
      write_reg(CFG_STEP, {9'($urandom), pick_step()});
      write_reg(CFG_RUN, {15'($urandom), 1'($urandom_range(0, 5) != 0)});
      if ($urandom_range(0, 3) == 0) write_reg(CFG_NONE, count_t'($urandom));
      tick_pct = $urandom_range(50, 100);
      ramp_pct = $urandom_range(3, 30);
      repeat (PHASE_ITEMS)
        send_item($urandom_range(0, 99) < tick_pct, $urandom_range(0, 99) < ramp_pct);
      drain_and_idle();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 25;
    stall_pct = 25;
    test_reset_defaults();
    test_wrap_without_toggle();
    test_toggle_levels();
    test_duty_clamp();
    test_halt_and_period_extremes();
    test_random_phases();
    if (led_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", led_q.size()));
    $display("sent %0d transactions, checked %0d results over %0d random register settings",
             items_sent, results_checked, PHASES);
    $display("output pin level changed %0d times", pin_changes);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
